>>> rtl/vrl_pkg.sv
// ---------------------------------------------------------------------------
// vrl_pkg: shared constants, types and helpers for the record log ring
// Sizes of the byte ring and descriptor ring, command codes, wrap helpers.
// ---------------------------------------------------------------------------
package vrl_pkg;

   localparam int BUFFER_BYTES = 64;
   localparam int MAX_RECORDS  = 16;

   localparam int PTR_W  = $clog2(BUFFER_BYTES);
   localparam int IDX_W  = $clog2(MAX_RECORDS);
   localparam int CNT_W  = $clog2(MAX_RECORDS + 1);
   localparam int FREE_W = $clog2(BUFFER_BYTES + 1);
   // compare width: holds free byte count and record_len + 1
   localparam int CMP_W  = ((FREE_W > 8) ? FREE_W : 8) + 1;
   localparam int DESC_W = 2 * PTR_W;

   typedef logic [PTR_W-1:0]  ptr_type;
   typedef logic [IDX_W-1:0]  idx_type;
   typedef logic [CNT_W-1:0]  cnt_type;
   typedef logic [CMP_W-1:0]  cmp_type;
   typedef logic [7:0]        byte_type;
   typedef logic [DESC_W-1:0] desc_type;

   localparam logic [1:0] CMD_WRITE  = 2'd0;
   localparam logic [1:0] CMD_DUMP   = 2'd1;
   localparam logic [1:0] CMD_STATUS = 2'd2;

   function automatic ptr_type ptr_inc(input ptr_type p);
      ptr_type r;
      if (p == ptr_type'(BUFFER_BYTES - 1)) r = '0;
      else r = p + ptr_type'(1);
      return r;
   endfunction

   function automatic idx_type idx_inc(input idx_type i);
      idx_type r;
      if (i == idx_type'(MAX_RECORDS - 1)) r = '0;
      else r = i + idx_type'(1);
      return r;
   endfunction

endpackage

>>> rtl/vrl_req_if.sv
// ---------------------------------------------------------------------------
// vrl_req_if: request channel of the record log ring
// Valid/ready handshake carrying a command, a data byte and a record length.
// ---------------------------------------------------------------------------
interface vrl_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] cmd;
   logic [7:0] data_byte;
   logic [7:0] record_len;

   modport source (output valid, output cmd, output data_byte, output record_len,
                   input ready);
   modport sink   (input valid, input cmd, input data_byte, input record_len,
                   output ready);
endinterface

>>> rtl/vrl_rsp_if.sv
// ---------------------------------------------------------------------------
// vrl_rsp_if: response channel of the record log ring
// Valid/ready handshake carrying dump bytes and status results.
// ---------------------------------------------------------------------------
interface vrl_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       record_end;
   logic       last;
   logic       empty_res;

   modport source (output valid, output out_byte, output record_end, output last,
                   output empty_res, input ready);
   modport sink   (input valid, input out_byte, input record_end, input last,
                   input empty_res, output ready);
endinterface

>>> rtl/vrl_ram.sv
// ---------------------------------------------------------------------------
// vrl_ram: generic simple dual-port RAM
// One write port, one read port, read data registered and held when idle.
// ---------------------------------------------------------------------------
module vrl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/variable_record_log_ring.sv
// ---------------------------------------------------------------------------
// variable_record_log_ring: log of variable-length records, oldest overwritten
// Beats inside a record are written in S_IDLE; an opening beat goes to S_EVICT,
//   then per eviction, bar one that empties the log, to S_EVICT_WAIT.
// A status query waits in S_STATUS for the output register. A dump reads each
//   record's descriptor, then each byte (byte RAM read, then output register).
// Reset clears the ring pointers and record count; dump state and RAMs are kept.
// ---------------------------------------------------------------------------
module variable_record_log_ring (
   input  logic        clock,
   input  logic        reset,
   vrl_req_if.sink     req,
   vrl_rsp_if.source   rsp
);

   localparam logic [2:0] S_IDLE       = 3'd0;
   localparam logic [2:0] S_EVICT      = 3'd1;
   localparam logic [2:0] S_EVICT_WAIT = 3'd2;
   localparam logic [2:0] S_DUMP_RD    = 3'd3;
   localparam logic [2:0] S_DUMP_DESC  = 3'd4;
   localparam logic [2:0] S_BYTE_RD    = 3'd5;
   localparam logic [2:0] S_BYTE_OUT   = 3'd6;
   localparam logic [2:0] S_STATUS     = 3'd7;

   logic [2:0]            state_ff, state_in;
   vrl_pkg::ptr_type      write_pos_ff, write_pos_in;
   vrl_pkg::ptr_type      oldest_ff, oldest_in;
   vrl_pkg::idx_type      head_ff, head_in;
   vrl_pkg::idx_type      tail_ff, tail_in;
   vrl_pkg::cnt_type      count_ff, count_in;
   logic [7:0]            bytes_left_ff, bytes_left_in;
   logic                  discard_ff, discard_in;
   vrl_pkg::ptr_type      open_start_ff, open_start_in;
   vrl_pkg::ptr_type      open_size_ff, open_size_in;
   vrl_pkg::byte_type     hold_byte_ff, hold_byte_in;
   logic [7:0]            hold_len_ff, hold_len_in;
   vrl_pkg::idx_type      dump_idx_ff, dump_idx_in;
   vrl_pkg::cnt_type      recs_ff, recs_in;
   vrl_pkg::ptr_type      dump_ptr_ff, dump_ptr_in;
   vrl_pkg::ptr_type      rem_ff, rem_in;
   vrl_pkg::ptr_type      n_ff, n_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   vrl_pkg::byte_type     out_byte_ff, out_byte_in;
   logic                  record_end_ff, record_end_in;
   logic                  last_ff, last_in;
   logic                  empty_ff, empty_in;

   logic                  b_we, b_re;
   vrl_pkg::ptr_type      b_waddr, b_raddr;
   vrl_pkg::byte_type     b_wdata, b_rdata;
   logic                  d_we, d_re;
   vrl_pkg::idx_type      d_waddr, d_raddr;
   vrl_pkg::desc_type     d_wdata, d_rdata;

   logic                  req_fire, out_free, out_load, need_evict, dump_last;
   vrl_pkg::cmp_type      free_bytes;
   vrl_pkg::idx_type      tail_next;

   vrl_ram #(.WIDTH(8), .DEPTH(vrl_pkg::BUFFER_BYTES)) u_byte_ram (
      .clock   (clock),
      .wr_en   (b_we),
      .wr_addr (b_waddr),
      .wr_data (b_wdata),
      .rd_en   (b_re),
      .rd_addr (b_raddr),
      .rd_data (b_rdata)
   );

   vrl_ram #(.WIDTH(vrl_pkg::DESC_W), .DEPTH(vrl_pkg::MAX_RECORDS)) u_desc_ram (
      .clock   (clock),
      .wr_en   (d_we),
      .wr_addr (d_waddr),
      .wr_data (d_wdata),
      .rd_en   (d_re),
      .rd_addr (d_raddr),
      .rd_data (d_rdata)
   );

   assign req.ready  = (state_ff == S_IDLE);
   assign req_fire   = req.valid && req.ready;
   assign out_free   = !rsp_valid_ff || rsp.ready;
   assign tail_next  = vrl_pkg::idx_inc(tail_ff);

   always_comb begin
      if (write_pos_ff >= oldest_ff) begin
         free_bytes = vrl_pkg::cmp_type'(vrl_pkg::BUFFER_BYTES)
                    - (vrl_pkg::cmp_type'(write_pos_ff) - vrl_pkg::cmp_type'(oldest_ff));
      end else begin
         free_bytes = vrl_pkg::cmp_type'(oldest_ff) - vrl_pkg::cmp_type'(write_pos_ff);
      end
   end

   assign need_evict = (count_ff >= vrl_pkg::cnt_type'(vrl_pkg::MAX_RECORDS))
                    || ((count_ff != '0)
                        && (free_bytes <= vrl_pkg::cmp_type'(hold_len_ff)
                                          + vrl_pkg::cmp_type'(1)));

   assign dump_last = ((rem_ff == vrl_pkg::ptr_type'(1))
                       && (recs_ff == vrl_pkg::cnt_type'(1)))
                   || (n_ff == vrl_pkg::ptr_type'(vrl_pkg::BUFFER_BYTES - 3));

   always_comb begin
      state_in      = state_ff;
      write_pos_in  = write_pos_ff;
      oldest_in     = oldest_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      bytes_left_in = bytes_left_ff;
      discard_in    = discard_ff;
      open_start_in = open_start_ff;
      open_size_in  = open_size_ff;
      hold_byte_in  = hold_byte_ff;
      hold_len_in   = hold_len_ff;
      dump_idx_in   = dump_idx_ff;
      recs_in       = recs_ff;
      dump_ptr_in   = dump_ptr_ff;
      rem_in        = rem_ff;
      n_in          = n_ff;
      out_byte_in   = out_byte_ff;
      record_end_in = record_end_ff;
      last_in       = last_ff;
      empty_in      = empty_ff;
      out_load      = 1'b0;
      b_we          = 1'b0;
      b_waddr       = write_pos_ff;
      b_wdata       = hold_byte_ff;
      b_re          = 1'b0;
      b_raddr       = dump_ptr_ff;
      d_we          = 1'b0;
      d_waddr       = head_ff;
      d_wdata       = {open_start_ff, open_size_ff};
      d_re          = 1'b0;
      d_raddr       = dump_idx_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               priority if (req.cmd == vrl_pkg::CMD_WRITE) begin
                  if (bytes_left_ff != '0) begin
                     // continue the open record
                     if (!discard_ff) begin
                        b_we         = 1'b1;
                        b_wdata      = req.data_byte;
                        write_pos_in = vrl_pkg::ptr_inc(write_pos_ff);
                     end
                     bytes_left_in = bytes_left_ff - 8'd1;
                     if (bytes_left_ff == 8'd1) begin
                        discard_in = 1'b0;
                        if (!discard_ff) begin
                           d_we     = 1'b1;
                           head_in  = vrl_pkg::idx_inc(head_ff);
                           count_in = count_ff + vrl_pkg::cnt_type'(1);
                           if (count_ff == '0) oldest_in = open_start_ff;
                        end
                     end
                  end else if (req.record_len == 8'd0) begin
                     // drop zero-length record
                  end else if (vrl_pkg::cmp_type'(req.record_len)
                               > vrl_pkg::cmp_type'(vrl_pkg::BUFFER_BYTES - 2)) begin
                     discard_in    = 1'b1;
                     bytes_left_in = req.record_len - 8'd1;
                  end else begin
                     hold_byte_in = req.data_byte;
                     hold_len_in  = req.record_len;
                     state_in     = S_EVICT;
                  end
               end else if (req.cmd == vrl_pkg::CMD_DUMP) begin
                  if (count_ff != '0) begin
                     dump_idx_in = tail_ff;
                     recs_in     = count_ff;
                     n_in        = '0;
                     state_in    = S_DUMP_RD;
                  end
               end else if (req.cmd == vrl_pkg::CMD_STATUS) begin
                  state_in = S_STATUS;
               end else begin
                  // unused command: no result
               end
            end
         end

         S_EVICT: begin
            if (need_evict) begin
               tail_in  = tail_next;
               count_in = count_ff - vrl_pkg::cnt_type'(1);
               if (count_ff == vrl_pkg::cnt_type'(1)) begin
                  oldest_in = write_pos_ff;
               end else begin
                  d_re     = 1'b1;
                  d_raddr  = tail_next;
                  state_in = S_EVICT_WAIT;
               end
            end else begin
               // open the record and store its first byte
               open_start_in = write_pos_ff;
               open_size_in  = vrl_pkg::ptr_type'(hold_len_ff);
               discard_in    = 1'b0;
               b_we          = 1'b1;
               write_pos_in  = vrl_pkg::ptr_inc(write_pos_ff);
               bytes_left_in = hold_len_ff - 8'd1;
               if (hold_len_ff == 8'd1) begin
                  d_we     = 1'b1;
                  d_wdata  = {write_pos_ff, vrl_pkg::ptr_type'(hold_len_ff)};
                  head_in  = vrl_pkg::idx_inc(head_ff);
                  count_in = count_ff + vrl_pkg::cnt_type'(1);
                  if (count_ff == '0) oldest_in = write_pos_ff;
               end
               state_in = S_IDLE;
            end
         end

         S_EVICT_WAIT: begin
            oldest_in = d_rdata[vrl_pkg::DESC_W-1 -: vrl_pkg::PTR_W];
            state_in  = S_EVICT;
         end

         S_DUMP_RD: begin
            d_re     = 1'b1;
            state_in = S_DUMP_DESC;
         end

         S_DUMP_DESC: begin
            dump_ptr_in = d_rdata[vrl_pkg::DESC_W-1 -: vrl_pkg::PTR_W];
            rem_in      = d_rdata[vrl_pkg::PTR_W-1:0];
            state_in    = S_BYTE_RD;
         end

         S_BYTE_RD: begin
            // issue the read only when the output register frees up next cycle
            if (out_free) begin
               b_re     = 1'b1;
               state_in = S_BYTE_OUT;
            end
         end

         S_BYTE_OUT: begin
            out_load      = 1'b1;
            out_byte_in   = b_rdata;
            record_end_in = (rem_ff == vrl_pkg::ptr_type'(1));
            last_in       = dump_last;
            empty_in      = 1'b0;
            n_in          = n_ff + vrl_pkg::ptr_type'(1);
            dump_ptr_in   = vrl_pkg::ptr_inc(dump_ptr_ff);
            rem_in        = rem_ff - vrl_pkg::ptr_type'(1);
            priority if (dump_last) begin
               state_in = S_IDLE;
            end else if (rem_ff == vrl_pkg::ptr_type'(1)) begin
               dump_idx_in = vrl_pkg::idx_inc(dump_idx_ff);
               recs_in     = recs_ff - vrl_pkg::cnt_type'(1);
               state_in    = S_DUMP_RD;
            end else begin
               state_in = S_BYTE_RD;
            end
         end

         S_STATUS: begin
            if (out_free) begin
               out_load      = 1'b1;
               out_byte_in   = '0;
               record_end_in = 1'b0;
               last_in       = 1'b1;
               empty_in      = (count_ff == '0);
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      priority if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         write_pos_ff  <= '0;
         oldest_ff     <= '0;
         head_ff       <= '0;
         tail_ff       <= '0;
         count_ff      <= '0;
         bytes_left_ff <= '0;
         discard_ff    <= 1'b0;
         open_start_ff <= '0;
         open_size_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         write_pos_ff  <= write_pos_in;
         oldest_ff     <= oldest_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         count_ff      <= count_in;
         bytes_left_ff <= bytes_left_in;
         discard_ff    <= discard_in;
         open_start_ff <= open_start_in;
         open_size_ff  <= open_size_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_byte_ff  <= hold_byte_in;
      hold_len_ff   <= hold_len_in;
      dump_idx_ff   <= dump_idx_in;
      recs_ff       <= recs_in;
      dump_ptr_ff   <= dump_ptr_in;
      rem_ff        <= rem_in;
      n_ff          <= n_in;
      out_byte_ff   <= out_byte_in;
      record_end_ff <= record_end_in;
      last_ff       <= last_in;
      empty_ff      <= empty_in;
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.out_byte   = out_byte_ff;
   assign rsp.record_end = record_end_ff;
   assign rsp.last       = last_ff;
   assign rsp.empty_res  = empty_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= vrl_pkg::cnt_type'(vrl_pkg::MAX_RECORDS))
      else $error("record count above descriptor ring depth");

   a_discard_open: assert property (@(posedge clock) disable iff (reset)
      discard_ff |-> (bytes_left_ff != '0))
      else $error("discard flag set with no bytes pending");

   a_out_no_overrun: assert property (@(posedge clock) disable iff (reset)
      out_load |-> (!rsp_valid_ff || rsp.ready))
      else $error("output register overwritten while a beat is pending");

   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && count_ff == '0 && bytes_left_ff == '0)
      |-> (oldest_ff == write_pos_ff))
      else $error("empty log with oldest pointer apart from write pointer");

endmodule
